// ----- design/operator_symbol_lexer_top_macros.svh -----
// Assertion macros for the operator symbol lexer.
`ifndef OPERATOR_SYMBOL_LEXER_TOP_MACROS_SVH
`define OPERATOR_SYMBOL_LEXER_TOP_MACROS_SVH

// Implication checked at every rising clk edge outside reset.
`define OSL_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define OSL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/osl_pkg.sv -----
// Shared types, token codes and widths for the operator symbol lexer.
package osl_pkg;

    localparam int LINE_BITS      = 32;
    localparam int LINE_OUT_WIDTH = 32;
    localparam int BYTE_WIDTH     = 8;
    localparam int CODE_WIDTH     = 8;
    localparam int LEN_WIDTH      = 2;
    localparam int S_TDATA_WIDTH  = 24;
    localparam int M_TDATA_WIDTH  = 48;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [LEN_WIDTH-1:0] LEN_NONE  = 2'd0;
    localparam logic [LEN_WIDTH-1:0] LEN_ONE   = 2'd1;
    localparam logic [LEN_WIDTH-1:0] LEN_TWO   = 2'd2;
    localparam logic [LEN_WIDTH-1:0] LEN_THREE = 2'd3;

    // Token codes
    localparam logic [CODE_WIDTH-1:0] TOK_NONE        = 8'h00;
    localparam logic [CODE_WIDTH-1:0] TOK_HASH        = 8'h01;
    localparam logic [CODE_WIDTH-1:0] TOK_DOLLAR      = 8'h02;
    localparam logic [CODE_WIDTH-1:0] TOK_DOLLAR2     = 8'h03;
    localparam logic [CODE_WIDTH-1:0] TOK_BACKSLASH   = 8'h04;
    localparam logic [CODE_WIDTH-1:0] TOK_NEWLINE     = 8'h05;
    localparam logic [CODE_WIDTH-1:0] TOK_NOT         = 8'h80;
    localparam logic [CODE_WIDTH-1:0] TOK_NE          = 8'h81;
    localparam logic [CODE_WIDTH-1:0] TOK_MOD         = 8'h82;
    localparam logic [CODE_WIDTH-1:0] TOK_AND         = 8'h83;
    localparam logic [CODE_WIDTH-1:0] TOK_LAND        = 8'h84;
    localparam logic [CODE_WIDTH-1:0] TOK_LPAREN      = 8'h85;
    localparam logic [CODE_WIDTH-1:0] TOK_RPAREN      = 8'h86;
    localparam logic [CODE_WIDTH-1:0] TOK_MUL         = 8'h87;
    localparam logic [CODE_WIDTH-1:0] TOK_ADD         = 8'h88;
    localparam logic [CODE_WIDTH-1:0] TOK_INC         = 8'h89;
    localparam logic [CODE_WIDTH-1:0] TOK_COMMA       = 8'h8b;
    localparam logic [CODE_WIDTH-1:0] TOK_SUB         = 8'h8c;
    localparam logic [CODE_WIDTH-1:0] TOK_DEC         = 8'h8d;
    localparam logic [CODE_WIDTH-1:0] TOK_ARROW       = 8'h8f;
    localparam logic [CODE_WIDTH-1:0] TOK_DOT         = 8'h90;
    localparam logic [CODE_WIDTH-1:0] TOK_ELLIPSIS    = 8'h91;
    localparam logic [CODE_WIDTH-1:0] TOK_DIV         = 8'h92;
    localparam logic [CODE_WIDTH-1:0] TOK_COLON       = 8'h93;
    localparam logic [CODE_WIDTH-1:0] TOK_SEMI        = 8'h94;
    localparam logic [CODE_WIDTH-1:0] TOK_LT          = 8'h95;
    localparam logic [CODE_WIDTH-1:0] TOK_SHL         = 8'h96;
    localparam logic [CODE_WIDTH-1:0] TOK_LE          = 8'h97;
    localparam logic [CODE_WIDTH-1:0] TOK_ASSIGN      = 8'h98;
    localparam logic [CODE_WIDTH-1:0] TOK_MOD_ASSIGN  = 8'h99;
    localparam logic [CODE_WIDTH-1:0] TOK_AND_ASSIGN  = 8'h9a;
    localparam logic [CODE_WIDTH-1:0] TOK_MUL_ASSIGN  = 8'h9b;
    localparam logic [CODE_WIDTH-1:0] TOK_ADD_ASSIGN  = 8'h9c;
    localparam logic [CODE_WIDTH-1:0] TOK_SUB_ASSIGN  = 8'h9d;
    localparam logic [CODE_WIDTH-1:0] TOK_DIV_ASSIGN  = 8'h9e;
    localparam logic [CODE_WIDTH-1:0] TOK_SHL_ASSIGN  = 8'h9f;
    localparam logic [CODE_WIDTH-1:0] TOK_EQ          = 8'ha0;
    localparam logic [CODE_WIDTH-1:0] TOK_SHR_ASSIGN  = 8'ha1;
    localparam logic [CODE_WIDTH-1:0] TOK_XOR_ASSIGN  = 8'ha2;
    localparam logic [CODE_WIDTH-1:0] TOK_OR_ASSIGN   = 8'ha3;
    localparam logic [CODE_WIDTH-1:0] TOK_GT          = 8'ha4;
    localparam logic [CODE_WIDTH-1:0] TOK_GE          = 8'ha5;
    localparam logic [CODE_WIDTH-1:0] TOK_SHR         = 8'ha6;
    localparam logic [CODE_WIDTH-1:0] TOK_QUESTION    = 8'ha7;
    localparam logic [CODE_WIDTH-1:0] TOK_LBRACKET    = 8'ha8;
    localparam logic [CODE_WIDTH-1:0] TOK_RBRACKET    = 8'ha9;
    localparam logic [CODE_WIDTH-1:0] TOK_XOR         = 8'haa;
    localparam logic [CODE_WIDTH-1:0] TOK_LBRACE      = 8'hab;
    localparam logic [CODE_WIDTH-1:0] TOK_OR          = 8'hac;
    localparam logic [CODE_WIDTH-1:0] TOK_LOR         = 8'had;
    localparam logic [CODE_WIDTH-1:0] TOK_RBRACE      = 8'hae;
    localparam logic [CODE_WIDTH-1:0] TOK_TILDE       = 8'haf;

    typedef struct packed {
        logic                  matched;
        logic [CODE_WIDTH-1:0] code;
        logic [LEN_WIDTH-1:0]  length;
    } token_t;

    typedef struct packed {
        logic fire;
        logic restart;
        logic newline;
    } count_ctrl_t;

endpackage

// ----- design/osl_classifier.sv -----
// Longest-match recognizer for operators, punctuation and newlines.
module osl_classifier (
    input  logic [osl_pkg::BYTE_WIDTH-1:0] first_byte,
    input  logic [osl_pkg::BYTE_WIDTH-1:0] second_byte,
    input  logic [osl_pkg::BYTE_WIDTH-1:0] third_byte,
    output osl_pkg::token_t                token
);
    import osl_pkg::*;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_QUEST  = 8'h3f;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRK   = 8'h5d;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_PIPE   = 8'h7c;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_TILDE  = 8'h7e;

    logic [CODE_WIDTH-1:0] code;
    logic [LEN_WIDTH-1:0]  length;

    always_comb
    begin
        code   = TOK_NONE;
        length = LEN_NONE;
        case (first_byte)
            CH_LF:
            begin
                code = TOK_NEWLINE; length = LEN_ONE;
            end
            CH_CR:
            begin
                code   = TOK_NEWLINE;
                length = (second_byte == CH_LF) ? LEN_TWO : LEN_ONE;
            end
            CH_BANG:
            begin
                if (second_byte == CH_EQ) begin code = TOK_NE; length = LEN_TWO; end
                else begin code = TOK_NOT; length = LEN_ONE; end
            end
            CH_HASH:
            begin
                code = TOK_HASH; length = LEN_ONE;
            end
            CH_DOLLAR:
            begin
                if (second_byte == CH_DOLLAR) begin code = TOK_DOLLAR2; length = LEN_TWO; end
                else begin code = TOK_DOLLAR; length = LEN_ONE; end
            end
            CH_PCT:
            begin
                if (second_byte == CH_EQ) begin code = TOK_MOD_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_MOD; length = LEN_ONE; end
            end
            CH_AMP:
            begin
                if (second_byte == CH_AMP) begin code = TOK_LAND; length = LEN_TWO; end
                else if (second_byte == CH_EQ) begin code = TOK_AND_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_AND; length = LEN_ONE; end
            end
            CH_LPAR:
            begin
                code = TOK_LPAREN; length = LEN_ONE;
            end
            CH_RPAR:
            begin
                code = TOK_RPAREN; length = LEN_ONE;
            end
            CH_STAR:
            begin
                if (second_byte == CH_EQ) begin code = TOK_MUL_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_MUL; length = LEN_ONE; end
            end
            CH_PLUS:
            begin
                if (second_byte == CH_PLUS) begin code = TOK_INC; length = LEN_TWO; end
                else if (second_byte == CH_EQ) begin code = TOK_ADD_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_ADD; length = LEN_ONE; end
            end
            CH_COMMA:
            begin
                code = TOK_COMMA; length = LEN_ONE;
            end
            CH_MINUS:
            begin
                if (second_byte == CH_MINUS) begin code = TOK_DEC; length = LEN_TWO; end
                else if (second_byte == CH_EQ) begin code = TOK_SUB_ASSIGN; length = LEN_TWO; end
                else if (second_byte == CH_GT) begin code = TOK_ARROW; length = LEN_TWO; end
                else begin code = TOK_SUB; length = LEN_ONE; end
            end
            CH_DOT:
            begin
                if (second_byte == CH_DOT && third_byte == CH_DOT)
                begin
                    code = TOK_ELLIPSIS; length = LEN_THREE;
                end
                else begin code = TOK_DOT; length = LEN_ONE; end
            end
            CH_SLASH:
            begin
                if (second_byte == CH_EQ) begin code = TOK_DIV_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_DIV; length = LEN_ONE; end
            end
            CH_COLON:
            begin
                code = TOK_COLON; length = LEN_ONE;
            end
            CH_SEMI:
            begin
                code = TOK_SEMI; length = LEN_ONE;
            end
            CH_LT:
            begin
                if (second_byte == CH_LT && third_byte == CH_EQ)
                begin
                    code = TOK_SHL_ASSIGN; length = LEN_THREE;
                end
                else if (second_byte == CH_LT) begin code = TOK_SHL; length = LEN_TWO; end
                else if (second_byte == CH_EQ) begin code = TOK_LE; length = LEN_TWO; end
                else begin code = TOK_LT; length = LEN_ONE; end
            end
            CH_EQ:
            begin
                if (second_byte == CH_EQ) begin code = TOK_EQ; length = LEN_TWO; end
                else begin code = TOK_ASSIGN; length = LEN_ONE; end
            end
            CH_GT:
            begin
                if (second_byte == CH_GT && third_byte == CH_EQ)
                begin
                    code = TOK_SHR_ASSIGN; length = LEN_THREE;
                end
                else if (second_byte == CH_GT) begin code = TOK_SHR; length = LEN_TWO; end
                else if (second_byte == CH_EQ) begin code = TOK_GE; length = LEN_TWO; end
                else begin code = TOK_GT; length = LEN_ONE; end
            end
            CH_QUEST:
            begin
                code = TOK_QUESTION; length = LEN_ONE;
            end
            CH_LBRK:
            begin
                code = TOK_LBRACKET; length = LEN_ONE;
            end
            CH_BSLASH:
            begin
                code = TOK_BACKSLASH; length = LEN_ONE;
            end
            CH_RBRK:
            begin
                code = TOK_RBRACKET; length = LEN_ONE;
            end
            CH_CARET:
            begin
                if (second_byte == CH_EQ) begin code = TOK_XOR_ASSIGN; length = LEN_TWO; end
                else begin code = TOK_XOR; length = LEN_ONE; end
            end
            CH_LBRACE:
            begin
                code = TOK_LBRACE; length = LEN_ONE;
            end
            CH_PIPE:
            begin
                if (second_byte == CH_EQ) begin code = TOK_OR_ASSIGN; length = LEN_TWO; end
                else if (second_byte == CH_PIPE) begin code = TOK_LOR; length = LEN_TWO; end
                else begin code = TOK_OR; length = LEN_ONE; end
            end
            CH_RBRACE:
            begin
                code = TOK_RBRACE; length = LEN_ONE;
            end
            CH_TILDE:
            begin
                code = TOK_TILDE; length = LEN_ONE;
            end
            default:
            begin
                code   = TOK_NONE;
                length = LEN_NONE;
            end
        endcase
    end

    assign token.matched = (length != LEN_NONE);
    assign token.code    = code;
    assign token.length  = length;

endmodule

// ----- design/osl_line_counter.sv -----
// Saturating line counter with restart, advanced once per newline transaction.
module osl_line_counter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  osl_pkg::count_ctrl_t           ctrl,
    output logic [osl_pkg::LINE_BITS-1:0]  line_next
);
    import osl_pkg::*;

    logic [LINE_BITS-1:0] line_count_reg;
    logic [LINE_BITS-1:0] base;

    assign base      = ctrl.restart ? LINE_ONE : line_count_reg;
    assign line_next = (ctrl.newline && base != LINE_MAX) ? base + LINE_ONE : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_ONE;
        end
        else if (ctrl.fire)
        begin
            line_count_reg <= line_next;
        end
    end

endmodule

// ----- design/operator_symbol_lexer_top.sv -----
// Operator symbol lexer: input register, classifier, line counter and result register.
//
// Each transaction on the slave side carries a three-byte window at the current text
// position; one result transaction comes out for each, in order. The block takes one
// window per cycle unless the result side stalls: the classifier and the line counter
// increment sit between the input register and the result register, and a stalled
// result register holds one item while the input register holds the next. The line
// count restarts at 1 when start_of_text is set, grows by one per newline token (CR,
// LF or CR-LF) and saturates at its maximum.
module operator_symbol_lexer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_byte [7:0], second_byte [15:8], third_byte [23:16]
    input  logic [osl_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // start_of_text [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // token_code [7:0], token_length [9:8], line_number [41:10], zero [47:42]
    output logic [osl_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    // matched [0]
    output logic                              m_tuser
);
    import osl_pkg::*;

    `include "operator_symbol_lexer_top_macros.svh"

    logic                      in_valid_reg;
    logic                      in_start_reg;
    logic [S_TDATA_WIDTH-1:0]  in_data_reg;
    logic                      out_valid_reg;
    token_t                    out_token_reg;
    logic [LINE_BITS-1:0]      out_line_reg;

    logic                      advance;
    token_t                    token;
    count_ctrl_t               count_ctrl;
    logic [LINE_BITS-1:0]      line_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    osl_classifier u_classifier (
        .first_byte  (in_data_reg[7:0]),
        .second_byte (in_data_reg[15:8]),
        .third_byte  (in_data_reg[23:16]),
        .token       (token)
    );

    assign count_ctrl.fire    = advance;
    assign count_ctrl.restart = in_start_reg;
    assign count_ctrl.newline = token.matched && (token.code == TOK_NEWLINE);

    osl_line_counter u_line_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (count_ctrl),
        .line_next (line_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_start_reg <= s_tuser;
            in_data_reg  <= s_tdata;
        end
        if (advance)
        begin
            out_token_reg <= token;
            out_line_reg  <= line_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_token_reg.matched;
    assign m_tdata  = {6'd0, LINE_OUT_WIDTH'(out_line_reg),
                       out_token_reg.length, out_token_reg.code};

    `OSL_ASSERT_IMPL(a_unmatched_zero, m_tvalid && !m_tuser, m_tdata[9:0] == 10'd0, "unmatched result carries code or length")
    `OSL_ASSERT_IMPL(a_matched_len, m_tvalid && m_tuser, m_tdata[9:8] != LEN_NONE, "matched result with zero length")
    `OSL_ASSERT_IMPL(a_line_nonzero, m_tvalid, m_tdata[41:10] != 32'd0, "line number is zero")
    `OSL_ASSERT_IMPL(a_stall_cause, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled without a full pipeline")
    `OSL_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "advanced item missing from result register")

endmodule

// ----- test/lexer_checker.sv -----
// Result checker for the operator symbol lexer: predicts each result and compares it.
`timescale 1ns / 100ps

module lexer_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // first_byte [7:0], second_byte [15:8], third_byte [23:16]
    input  logic [osl_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // start_of_text [0]
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // token_code [7:0], token_length [9:8], line_number [41:10], zero [47:42]
    input  logic [osl_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    // matched [0]
    input  logic                              m_tuser,
    output int                                fail_count,
    output int                                waiting
);

    import osl_pkg::*;

    localparam logic [BYTE_WIDTH-1:0] CHR_LF = 8'h0a;
    localparam logic [BYTE_WIDTH-1:0] CHR_CR = 8'h0d;
    localparam int LINE_LSB = CODE_WIDTH + LEN_WIDTH;
    localparam int PAD_LSB  = LINE_LSB + LINE_OUT_WIDTH;

    typedef struct packed {
        token_t                    tok;
        logic [LINE_OUT_WIDTH-1:0] line;
    } lex_result_t;

    lex_result_t          token_q[$];
    logic [LINE_BITS-1:0] line_count;
    int                   fails = 0;

    function automatic token_t tok1(input logic [CODE_WIDTH-1:0] code);
        return '{matched: 1'b1, code: code, length: LEN_ONE};
    endfunction

    function automatic token_t tok2(input logic [CODE_WIDTH-1:0] code);
        return '{matched: 1'b1, code: code, length: LEN_TWO};
    endfunction

    function automatic token_t tok3(input logic [CODE_WIDTH-1:0] code);
        return '{matched: 1'b1, code: code, length: LEN_THREE};
    endfunction

    // Longest match of up to three characters at the head of the window.
    function automatic token_t scan_symbol(input logic [BYTE_WIDTH-1:0] c0, c1, c2);
        token_t t;
        t = '{matched: 1'b0, code: TOK_NONE, length: LEN_NONE};
        case (c0)
            CHR_LF: t = tok1(TOK_NEWLINE);
            CHR_CR: t = (c1 == CHR_LF) ? tok2(TOK_NEWLINE) : tok1(TOK_NEWLINE);
            "!":    t = (c1 == "=") ? tok2(TOK_NE) : tok1(TOK_NOT);
            "#":    t = tok1(TOK_HASH);
            "$":    t = (c1 == "$") ? tok2(TOK_DOLLAR2) : tok1(TOK_DOLLAR);
            "%":    t = (c1 == "=") ? tok2(TOK_MOD_ASSIGN) : tok1(TOK_MOD);
            "&":
            begin
                if (c1 == "&")      t = tok2(TOK_LAND);
                else if (c1 == "=") t = tok2(TOK_AND_ASSIGN);
                else                t = tok1(TOK_AND);
            end
            "(":    t = tok1(TOK_LPAREN);
            ")":    t = tok1(TOK_RPAREN);
            "*":    t = (c1 == "=") ? tok2(TOK_MUL_ASSIGN) : tok1(TOK_MUL);
            "+":
            begin
                if (c1 == "+")      t = tok2(TOK_INC);
                else if (c1 == "=") t = tok2(TOK_ADD_ASSIGN);
                else                t = tok1(TOK_ADD);
            end
            ",":    t = tok1(TOK_COMMA);
            "-":
            begin
                if (c1 == "-")      t = tok2(TOK_DEC);
                else if (c1 == "=") t = tok2(TOK_SUB_ASSIGN);
                else if (c1 == ">") t = tok2(TOK_ARROW);
                else                t = tok1(TOK_SUB);
            end
            ".":    t = (c1 == "." && c2 == ".") ? tok3(TOK_ELLIPSIS) : tok1(TOK_DOT);
            "/":    t = (c1 == "=") ? tok2(TOK_DIV_ASSIGN) : tok1(TOK_DIV);
            ":":    t = tok1(TOK_COLON);
            ";":    t = tok1(TOK_SEMI);
            "<":
            begin
                if (c1 == "<" && c2 == "=") t = tok3(TOK_SHL_ASSIGN);
                else if (c1 == "<")         t = tok2(TOK_SHL);
                else if (c1 == "=")         t = tok2(TOK_LE);
                else                        t = tok1(TOK_LT);
            end
            "=":    t = (c1 == "=") ? tok2(TOK_EQ) : tok1(TOK_ASSIGN);
            ">":
            begin
                if (c1 == ">" && c2 == "=") t = tok3(TOK_SHR_ASSIGN);
                else if (c1 == ">")         t = tok2(TOK_SHR);
                else if (c1 == "=")         t = tok2(TOK_GE);
                else                        t = tok1(TOK_GT);
            end
            "?":    t = tok1(TOK_QUESTION);
            "[":    t = tok1(TOK_LBRACKET);
            "\\":   t = tok1(TOK_BACKSLASH);
            "]":    t = tok1(TOK_RBRACKET);
            "^":    t = (c1 == "=") ? tok2(TOK_XOR_ASSIGN) : tok1(TOK_XOR);
            "{":    t = tok1(TOK_LBRACE);
            "|":
            begin
                if (c1 == "=")      t = tok2(TOK_OR_ASSIGN);
                else if (c1 == "|") t = tok2(TOK_LOR);
                else                t = tok1(TOK_OR);
            end
            "}":    t = tok1(TOK_RBRACE);
            "~":    t = tok1(TOK_TILDE);
            default: ;
        endcase
        return t;
    endfunction

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        lex_result_t want;
        token_t      tok;
        if (!rst_n)
        begin
            line_count = LINE_ONE;
            token_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    line_count = LINE_ONE;
                tok = scan_symbol(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
                if (tok.matched && tok.code == TOK_NEWLINE && line_count != LINE_MAX)
                    line_count = line_count + LINE_ONE;
                want.tok  = tok;
                want.line = LINE_OUT_WIDTH'(line_count);
                token_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, actual 0x%0h / %b",
                             $time, m_tdata, m_tuser);
                    fails++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (m_tuser !== want.tok.matched)
                        report("matched", 64'(want.tok.matched), 64'(m_tuser));
                    if (m_tdata[CODE_WIDTH-1:0] !== want.tok.code)
                        report("token_code", 64'(want.tok.code),
                               64'(m_tdata[CODE_WIDTH-1:0]));
                    if (m_tdata[CODE_WIDTH +: LEN_WIDTH] !== want.tok.length)
                        report("token_length", 64'(want.tok.length),
                               64'(m_tdata[CODE_WIDTH +: LEN_WIDTH]));
                    if (m_tdata[LINE_LSB +: LINE_OUT_WIDTH] !== want.line)
                        report("line_number", 64'(want.line),
                               64'(m_tdata[LINE_LSB +: LINE_OUT_WIDTH]));
                    if (m_tdata[M_TDATA_WIDTH-1:PAD_LSB] !== '0)
                        report("tdata padding", 64'd0,
                               64'(m_tdata[M_TDATA_WIDTH-1:PAD_LSB]));
                end
            end
        end
        waiting    <= token_q.size();
        fail_count <= fails;
    end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the operator symbol lexer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    import osl_pkg::*;

    localparam int RANDOM_WINDOWS = 650;
    localparam int PHASE_WINDOWS  = RANDOM_WINDOWS / 3;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic                     m_tuser;

    int   fail_count;
    int   waiting;
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 78;
    int   phase_id    = 0;
    int   phase_sent  = 0;
    logic hold_off    = 1'b0;

    string symbol_chars = "\n\015!#$%&()*+,-./:;<=>?[\\]^{|}~";
    string follow_chars = "=<>.&|+-$\n";

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    operator_symbol_lexer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lexer_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);

    // Long output stall while the sender keeps pushing, to back up the pipeline.
    initial
    begin
        wait (phase_id == 3 && phase_sent >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic offer_window(input logic start, input logic [BYTE_WIDTH-1:0] c0, c1, c2);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {c2, c1, c0};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [BYTE_WIDTH-1:0] text_byte(input bit follow);
        int r;
        r = $urandom_range(99);
        if (follow && r < 40)
            return follow_chars[$urandom_range(follow_chars.len() - 1)];
        if (r < 70)
            return symbol_chars[$urandom_range(symbol_chars.len() - 1)];
        if (r < 80)
            return 8'h00;
        return BYTE_WIDTH'($urandom_range(255));
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_window(1'b0, 8'h00, 8'h00, 8'h00);
        offer_window(1'b0, 8'hff, 8'hff, 8'hff);
        offer_window(1'b1, "\n", "\n", 8'h00);
        offer_window(1'b0, 8'h0d, "\n", "x");
        offer_window(1'b0, 8'h0d, 8'h0d, "\n");
        offer_window(1'b0, "\n", 8'h00, 8'h00);
        offer_window(1'b1, "!", "=", "=");
        offer_window(1'b0, ".", ".", ".");
        offer_window(1'b0, ".", ".", 8'h00);
        offer_window(1'b0, "<", "<", "=");
        offer_window(1'b0, "<", "<", 8'h00);
        offer_window(1'b0, ">", ">", "=");
        offer_window(1'b0, ">", ">", ">");
        offer_window(1'b0, "-", ">", 8'h00);
        offer_window(1'b0, "-", "-", "-");
        offer_window(1'b0, "|", "|", "=");
        offer_window(1'b0, "|", "=", 8'h00);
        offer_window(1'b0, "&", "&", "=");
        offer_window(1'b0, "+", "+", "+");
        offer_window(1'b0, "$", "$", "$");
        offer_window(1'b0, "\\", 8'h00, 8'h00);
        offer_window(1'b0, "~", 8'hff, 8'hff);
        offer_window(1'b1, "a", 8'h0d, 8'h0d);
        offer_window(1'b0, 8'h0d, 8'h00, 8'h00);

        for (int p = 1; p <= 3; p++)
        begin
            case (p)
                1:
                begin
                    tx_idle_pct = 10;
                    rx_idle_pct <= 78;
                end
                2:
                begin
                    tx_idle_pct = 78;
                    rx_idle_pct <= 10;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            phase_id <= p;
            for (int i = 0; i < PHASE_WINDOWS; i++)
            begin
                offer_window($urandom_range(99) < 3, text_byte(1'b0), text_byte(1'b1),
                             text_byte(1'b1));
                phase_sent <= i + 1;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (waiting == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/osl_pkg.sv
design/osl_classifier.sv
design/osl_line_counter.sv
design/operator_symbol_lexer_top.sv
test/lexer_checker.sv
test/testbench.sv
